FILE: rtl/hmac_pkg.sv
package hmac_pkg;

  localparam logic [1:0] CMD_KEY = 2'd0;
  localparam logic [1:0] CMD_MSG = 2'd1;
  localparam logic [1:0] CMD_FIN = 2'd2;

  localparam logic [7:0] IPAD     = 8'h36;
  localparam logic [7:0] OPAD     = 8'h5C;
  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] tag_word;
    logic [2:0]  word_index;
    logic        last_word;
  } tag_t;

  // request from the HMAC sequencer to the hash core
  typedef struct packed {
    logic       init;    // restart hash: IV, empty buffer, zero length
    logic       push;    // absorb one byte
    logic       finish;  // pad and compress the final block(s)
    logic [7:0] data;
  } core_op_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

FILE: rtl/hmac_sha256_engine.sv
// HMAC-SHA256 engine. Send key bytes (cmd KEY), then message bytes (cmd MSG),
// then one FINISH; the tag comes out as eight 32-bit words, word 0 (most
// significant) first, with last_word on the eighth. The first MSG or FINISH
// closes the key; an empty key acts as 64 zero bytes, and a key longer than
// 64 bytes is hashed down to 32 bytes. KEY bytes during the message and
// command 3 are dropped. After the tag the key is cleared, so load a new one.
// Operation: one SHA-256 round unit does all the work, one round per cycle;
// each 64-byte block runs 64 rounds and then the chaining add. A key byte is
// just stored while the key fits in 64 bytes; the 65th key byte restarts the
// hash, replays the 64 stored bytes into it (one block) and then absorbs
// itself, and each later key byte is absorbed, plus one block compression
// when it completes a block. A message byte is absorbed likewise, plus one
// block compression when it completes a block. The first MSG or FINISH also
// closes the key: a short key is zero-filled to 64 bytes, then the inner pad
// block is fed and compressed; a long key first has its hash padded, one or
// two blocks compressed and the digest taken as key before the inner pad.
// FINISH pads the inner hash, feeds the outer key block and the inner digest
// and pads again: three or four compressions from the FINISH transaction to
// the first tag word when the key is already closed. Tag words then go out
// one per cycle unless stalled. item_stall stays high whenever the round
// unit or the sequencer is busy and while the tag is being delivered.
module hmac_sha256_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_stall,
  input  hmac_pkg::item_t item,
  output logic            tag_valid,
  input  logic            tag_stall,
  output hmac_pkg::tag_t  tag
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_KRAW  = 14'h0002,  // long key: replay first 64 key bytes into the hash
    S_PUSHP = 14'h0004,  // push the held byte
    S_KPAD  = 14'h0008,  // zero-fill a short key
    S_KFIN  = 14'h0010,
    S_KWAIT = 14'h0020,
    S_IPAD  = 14'h0040,
    S_FIN   = 14'h0080,
    S_FWAIT = 14'h0100,
    S_OPAD  = 14'h0200,
    S_INNER = 14'h0400,
    S_OFIN  = 14'h0800,
    S_OWAIT = 14'h1000,
    S_OUT   = 14'h2000
  } state_t;

  state_t             state;
  logic               phase;      // 1 once the key is closed
  logic [511:0]       key_store;  // bytes enter at the bottom; byte 0 ends on top
  logic [6:0]         key_len;    // saturates at 65 (means "longer than 64")
  logic [1:0]         pend_cmd;
  logic [7:0]         pend_byte;
  logic [5:0]         fcnt;
  logic [255:0]       inner;
  logic [255:0]       res;
  logic [2:0]         ocnt;
  logic               busy;
  logic               core_idle;
  logic               accept;
  logic [255:0]       digest;
  hmac_pkg::core_op_t op;

  hmac_core u_core (
    .clk    (clk),
    .rst    (rst),
    .op     (op),
    .busy   (busy),
    .digest (digest)
  );

  assign core_idle  = !busy;
  assign item_stall = !(state == S_IDLE && core_idle);
  assign accept     = item_valid && !item_stall;

  assign tag_valid      = (state == S_OUT);
  assign tag.tag_word   = res[255:224];
  assign tag.word_index = ocnt;
  assign tag.last_word  = (ocnt == 3'd7);

  // requests to the hash core
  always_comb begin
    op = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          op.data = item.data_byte;
          if (item.cmd == hmac_pkg::CMD_KEY && !phase) begin
            op.init = (key_len == 7'd64);
            op.push = (key_len == 7'd65);
          end else if (item.cmd == hmac_pkg::CMD_MSG && phase) begin
            op.push = 1'b1;
          end
        end
      end
      S_KRAW: begin
        op.push = core_idle;
        op.data = key_store[511:504];
      end
      S_PUSHP: begin
        op.push = core_idle;
        op.data = pend_byte;
      end
      S_KPAD: begin
        op.init = (key_len == 7'd64);
      end
      S_KFIN, S_FIN, S_OFIN: begin
        op.finish = core_idle;
      end
      S_KWAIT, S_FWAIT: begin
        op.init = core_idle;
      end
      S_IPAD: begin
        op.push = core_idle;
        op.data = key_store[511:504] ^ hmac_pkg::IPAD;
      end
      S_OPAD: begin
        op.push = core_idle;
        op.data = key_store[511:504] ^ hmac_pkg::OPAD;
      end
      S_INNER: begin
        op.push = core_idle;
        op.data = inner[255:248];
      end
      default: begin
        op = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= 1'b0;
      key_store <= '0;
      key_len   <= '0;
      fcnt      <= '0;
      ocnt      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend_cmd  <= item.cmd;
            pend_byte <= item.data_byte;
            case (item.cmd)
              hmac_pkg::CMD_KEY: begin
                if (!phase) begin
                  if (key_len < 7'd64) begin
                    key_store <= {key_store[503:0], item.data_byte};
                    key_len   <= key_len + 7'd1;
                  end else if (key_len == 7'd64) begin
                    key_len <= 7'd65;
                    fcnt    <= '0;
                    state   <= S_KRAW;
                  end
                end
              end
              hmac_pkg::CMD_MSG, hmac_pkg::CMD_FIN: begin
                if (!phase) begin
                  phase <= 1'b1;
                  state <= (key_len == 7'd65) ? S_KFIN : S_KPAD;
                end else if (item.cmd == hmac_pkg::CMD_FIN) begin
                  state <= S_FIN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_KRAW: begin
          if (core_idle) begin
            key_store <= {key_store[503:0], key_store[511:504]};
            fcnt      <= fcnt + 6'd1;
            if (fcnt == 6'd63) begin
              state <= S_PUSHP;
            end
          end
        end
        S_PUSHP: begin
          if (core_idle) begin
            state <= S_IDLE;
          end
        end
        S_KPAD: begin
          if (key_len == 7'd64) begin
            fcnt  <= '0;
            state <= S_IPAD;
          end else begin
            key_store <= {key_store[503:0], 8'h00};
            key_len   <= key_len + 7'd1;
          end
        end
        S_KFIN: begin
          if (core_idle) begin
            state <= S_KWAIT;
          end
        end
        S_KWAIT: begin
          if (core_idle) begin
            key_store <= {digest, 256'd0};
            fcnt      <= '0;
            state     <= S_IPAD;
          end
        end
        S_IPAD: begin
          if (core_idle) begin
            key_store <= {key_store[503:0], key_store[511:504]};
            fcnt      <= fcnt + 6'd1;
            if (fcnt == 6'd63) begin
              state <= (pend_cmd == hmac_pkg::CMD_MSG) ? S_PUSHP : S_FIN;
            end
          end
        end
        S_FIN: begin
          if (core_idle) begin
            state <= S_FWAIT;
          end
        end
        S_FWAIT: begin
          if (core_idle) begin
            inner <= digest;
            fcnt  <= '0;
            state <= S_OPAD;
          end
        end
        S_OPAD: begin
          if (core_idle) begin
            key_store <= {key_store[503:0], key_store[511:504]};
            fcnt      <= fcnt + 6'd1;
            if (fcnt == 6'd63) begin
              state <= S_INNER;
            end
          end
        end
        S_INNER: begin
          if (core_idle) begin
            inner <= {inner[247:0], 8'h00};
            fcnt  <= fcnt + 6'd1;
            if (fcnt == 6'd31) begin
              state <= S_OFIN;
            end
          end
        end
        S_OFIN: begin
          if (core_idle) begin
            state <= S_OWAIT;
          end
        end
        S_OWAIT: begin
          if (core_idle) begin
            res   <= digest;
            ocnt  <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!tag_stall) begin
            res  <= {res[223:0], 32'd0};
            ocnt <= ocnt + 3'd1;
            if (ocnt == 3'd7) begin
              // tag done: back to an empty key
              key_store <= '0;
              key_len   <= '0;
              phase     <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/hmac_core.sv
// SHA-256 byte absorber with one shared round unit.
module hmac_core (
  input  logic              clk,
  input  logic              rst,
  input  hmac_pkg::core_op_t op,
  output logic              busy,
  output logic [255:0]      digest
);

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_ROUND = 4'b0010,
    C_ADD   = 4'b0100,
    C_PAD   = 4'b1000
  } cstate_t;

  cstate_t      state;
  logic [31:0]  h [8];
  logic [31:0]  v [8];
  logic [31:0]  v_next [8];
  logic [511:0] sched;      // block buffer, then the 16-word schedule window
  logic [6:0]   fill;
  logic [63:0]  bitlen;
  logic [5:0]   rnd;
  logic         pad_act;
  logic         pad_first;
  logic         len_ok;     // the current block is the one that carries the length

  logic [31:0] w0, w1, w9, w14, s0, s1, w_new, t1, t2, ch, maj, sig0, sig1;
  logic [7:0]  pad_byte;

  assign busy   = (state != C_IDLE);
  assign digest = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};

  always_comb begin
    if (pad_first) begin
      pad_byte = hmac_pkg::PAD_MARK;
    end else if (fill >= 7'd56 && len_ok) begin
      pad_byte = 8'(bitlen >> {~fill[2:0], 3'b000});
    end else begin
      pad_byte = 8'h00;
    end
  end

  // one round of the compression
  always_comb begin
    w0    = sched[511:480];
    w1    = sched[479:448];
    w9    = sched[223:192];
    w14   = sched[63:32];
    s0    = hmac_pkg::rotr(w1, 7) ^ hmac_pkg::rotr(w1, 18) ^ (w1 >> 3);
    s1    = hmac_pkg::rotr(w14, 17) ^ hmac_pkg::rotr(w14, 19) ^ (w14 >> 10);
    w_new = s1 + w9 + s0 + w0;
    sig1  = hmac_pkg::rotr(v[4], 6) ^ hmac_pkg::rotr(v[4], 11) ^ hmac_pkg::rotr(v[4], 25);
    sig0  = hmac_pkg::rotr(v[0], 2) ^ hmac_pkg::rotr(v[0], 13) ^ hmac_pkg::rotr(v[0], 22);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + sig1 + ch + hmac_pkg::ROUND_K[rnd] + w0;
    t2    = sig0 + maj;
    v_next[0] = t1 + t2;
    v_next[1] = v[0];
    v_next[2] = v[1];
    v_next[3] = v[2];
    v_next[4] = v[3] + t1;
    v_next[5] = v[4];
    v_next[6] = v[5];
    v_next[7] = v[6];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= C_IDLE;
      pad_act <= 1'b0;
      fill    <= '0;
      bitlen  <= '0;
      h       <= hmac_pkg::SHA_IV;
    end else begin
      case (state)
        C_IDLE: begin
          if (op.init) begin
            h      <= hmac_pkg::SHA_IV;
            fill   <= '0;
            bitlen <= '0;
          end else if (op.push) begin
            sched  <= {sched[503:0], op.data};
            bitlen <= bitlen + 64'd8;
            fill   <= fill + 7'd1;
            if (fill == 7'd63) begin
              v     <= h;
              rnd   <= '0;
              state <= C_ROUND;
            end
          end else if (op.finish) begin
            pad_act   <= 1'b1;
            pad_first <= 1'b1;
            len_ok    <= (fill <= 7'd55);
            state     <= C_PAD;
          end
        end
        C_PAD: begin
          sched     <= {sched[503:0], pad_byte};
          pad_first <= 1'b0;
          fill      <= fill + 7'd1;
          if (fill == 7'd63) begin
            len_ok <= 1'b1;
            if (len_ok && !pad_first) begin
              pad_act <= 1'b0;
            end
            v     <= h;
            rnd   <= '0;
            state <= C_ROUND;
          end
        end
        C_ROUND: begin
          v     <= v_next;
          sched <= {sched[479:0], w_new};
          rnd   <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
          end
          fill  <= '0;
          state <= pad_act ? C_PAD : C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/hmac_chk.sv
module hmac_chk (
  input logic            clk,
  input logic            rst,
  input logic            item_valid,
  input logic            item_stall,
  input hmac_pkg::item_t item,
  input logic            tag_valid,
  input logic            tag_stall,
  input hmac_pkg::tag_t  tag
);

  a_tag_hold: assert property (@(posedge clk) disable iff (rst)
    tag_valid && tag_stall |=> tag_valid && $stable(tag))
    else $error("tag changed while stalled");

  a_no_take_during_tag: assert property (@(posedge clk) disable iff (rst)
    tag_valid |-> item_stall)
    else $error("input taken during tag delivery");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    tag_valid && !tag_stall && !tag.last_word |=>
      tag_valid && tag.word_index == 3'($past(tag.word_index) + 3'd1))
    else $error("tag word out of order");

  a_tag_end: assert property (@(posedge clk) disable iff (rst)
    tag_valid && !tag_stall && tag.last_word |=> !tag_valid)
    else $error("tag continues past last word");

  a_item_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_stall |=> item_valid && $stable(item))
    else $error("item changed while stalled");

endmodule

bind hmac_sha256_engine hmac_chk u_chk (.*);
